FILE: rtl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge outside reset
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// condition must never be seen outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`endif

FILE: rtl/tfb_pkg.sv
package tfb_pkg;

  localparam logic [7:0] HDR_BYTE    = 8'hAA;
  localparam logic [7:0] DEST_RESET  = 8'hFF;
  localparam int         MAX_RES     = 6;
  localparam int         CNT_W       = $clog2(MAX_RES + 1);
  localparam int         IDX_W       = $clog2(MAX_RES);
  localparam int         IN_DATA_W   = 24;

  typedef enum logic {
    CMD_START   = 1'b0,
    CMD_PAYLOAD = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] func_code;
    logic [7:0] payload_length;
    logic [7:0] payload_byte;
  } item_t;

  // bytes of one request's results, first byte in entry 0
  typedef struct packed {
    logic [MAX_RES-1:0][7:0] data;
    logic [CNT_W-1:0]        cnt;
    logic                    chk;
  } grp_t;

endpackage

FILE: rtl/tfb_frame_calc.sv
`include "assert_macros.svh"

module tfb_frame_calc import tfb_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  input  item_t      item,
  input  logic       take,
  output grp_t       grp
);

  logic [7:0] dest_r;
  logic       open_r, open_nxt;
  logic [7:0] rem_r, rem_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic [7:0] sos_r, sos_nxt;

  logic [7:0] s1, s2, s3, q1, q2, q3;
  logic [7:0] ps, pq, rem_dec;

  always_comb begin
    s1      = HDR_BYTE + dest_r;
    q1      = HDR_BYTE + s1;
    s2      = s1 + item.func_code;
    q2      = q1 + s2;
    s3      = s2 + item.payload_length;
    q3      = q2 + s3;
    ps      = sum_r + item.payload_byte;
    pq      = sos_r + ps;
    rem_dec = rem_r - 8'd1;

    grp      = '0;
    open_nxt = open_r;
    rem_nxt  = rem_r;
    sum_nxt  = sum_r;
    sos_nxt  = sos_r;

    unique case (item.cmd)
      CMD_START: begin
        grp.data[0] = HDR_BYTE;
        grp.data[1] = dest_r;
        grp.data[2] = item.func_code;
        grp.data[3] = item.payload_length;
        grp.data[4] = s3;
        grp.data[5] = q3;
        grp.chk     = (item.payload_length == 8'd0);
        grp.cnt     = grp.chk ? CNT_W'(6) : CNT_W'(4);
        open_nxt    = !grp.chk;
        rem_nxt     = item.payload_length;
        sum_nxt     = s3;
        sos_nxt     = q3;
      end
      CMD_PAYLOAD: begin
        if (open_r) begin
          grp.data[0] = item.payload_byte;
          grp.data[1] = ps;
          grp.data[2] = pq;
          grp.chk     = (rem_dec == 8'd0);
          grp.cnt     = grp.chk ? CNT_W'(3) : CNT_W'(1);
          open_nxt    = !grp.chk;
          rem_nxt     = rem_dec;
          sum_nxt     = ps;
          sos_nxt     = pq;
        end
      end
      default: begin
        grp = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dest_r <= DEST_RESET;
      open_r <= 1'b0;
      rem_r  <= '0;
      sum_r  <= '0;
      sos_r  <= '0;
    end else begin
      if (cfg_wr_en) begin
        dest_r <= cfg_wr_data;
      end
      if (take) begin
        open_r <= open_nxt;
        rem_r  <= rem_nxt;
        sum_r  <= sum_nxt;
        sos_r  <= sos_nxt;
      end
    end
  end

  `ASSERT_PROP(a_open_has_rem, clk, rst_n, open_r |-> rem_r != 8'd0)
  `ASSERT_PROP(a_start_opens, clk, rst_n,
    (take && item.cmd == CMD_START && item.payload_length != 8'd0)
      |=> (open_r && rem_r == $past(item.payload_length)))
  `ASSERT_PROP(a_stray_ignored, clk, rst_n,
    (take && item.cmd == CMD_PAYLOAD && !open_r)
      |=> ($stable(sum_r) && $stable(sos_r) && !open_r))

endmodule

FILE: rtl/tfb_out_buf.sv
`include "assert_macros.svh"

module tfb_out_buf import tfb_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  grp_t       grp,
  input  logic       load,
  output logic       free,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,
  output logic       out_tuser,
  output logic       out_tlast
);

  logic [MAX_RES-1:0][7:0] data_r;
  logic [CNT_W-1:0]        cnt_r;
  logic [IDX_W-1:0]        idx_r;
  logic                    chk_r;
  logic                    last;
  logic                    pop;

  assign out_tvalid = (cnt_r != '0);
  assign last       = (CNT_W'(idx_r) == CNT_W'(cnt_r - CNT_W'(1)));
  assign pop        = out_tvalid && out_tready;
  assign free       = !out_tvalid || (pop && last);
  assign out_tdata  = data_r[idx_r];
  assign out_tlast  = last;
  assign out_tuser  = chk_r && last;

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= grp.data;
      chk_r  <= grp.chk;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      idx_r <= '0;
    end else if (load) begin
      cnt_r <= grp.cnt;
      idx_r <= '0;
    end else if (pop && last) begin
      cnt_r <= '0;
      idx_r <= '0;
    end else if (pop) begin
      idx_r <= idx_r + IDX_W'(1);
    end
  end

  `ASSERT_NEVER(a_idx_in_range, clk, rst_n, out_tvalid && CNT_W'(idx_r) >= cnt_r)
  `ASSERT_PROP(a_end_is_last, clk, rst_n, (out_tvalid && out_tuser) |-> out_tlast)
  `ASSERT_PROP(a_load_when_free, clk, rst_n,
    load |-> (!out_tvalid || (pop && last)))

endmodule

FILE: rtl/telemetry_frame_builder.sv
// Telemetry frame builder. A start request (tuser 0) emits the header 0xAA, the destination
// address from cfg_wr_data, the function code and the payload length; each payload request
// (tuser 1) passes its byte through, and after the last payload byte (or right after the
// header for a zero length) the running-sum and sum-of-sums check bytes follow, the last
// (sum-of-sums) check byte flagged on out_tuser. A payload request with no frame open gives
// no output. Input requests are accepted one per cycle into an input register, except while
// that register holds a request the output buffer cannot yet take; each is worked out in a
// single pass. Results leave one byte per cycle through the output buffer while out_tready
// is high. A request makes 4 bytes for a start, 6 for an empty frame, 1 for payload, 3 for
// the final payload byte, 0 for a stray one; tlast marks the last byte of each input request.
module telemetry_frame_builder import tfb_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [7:0]           cfg_wr_data,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_DATA_W-1:0] in_tdata,   // func_code, payload_length, payload_byte
  input  logic                 in_tuser,   // cmd
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [7:0]           out_tdata,  // out_byte
  output logic                 out_tuser,  // frame_end
  output logic                 out_tlast   // run_last
);

  item_t item_r;
  logic  item_vld_r;
  logic  take;
  logic  free;
  grp_t  grp;

  assign take      = item_vld_r && free;
  assign in_tready = !item_vld_r || take;

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.cmd            <= cmd_t'(in_tuser);
      item_r.func_code      <= in_tdata[7:0];
      item_r.payload_length <= in_tdata[15:8];
      item_r.payload_byte   <= in_tdata[23:16];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (in_tready) begin
      item_vld_r <= in_tvalid;
    end
  end

  tfb_frame_calc u_calc (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .item        (item_r),
    .take        (take),
    .grp         (grp)
  );

  tfb_out_buf u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .grp        (grp),
    .load       (take && grp.cnt != '0),
    .free       (free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
